[sv/bb3_pkg.sv]
package bb3_pkg;

   // One pixel of the input stream.
   typedef struct packed {
      logic [7:0] red_in;
      logic [7:0] green_in;
      logic [7:0] blue_in;
   } pixel_type;

   // One blurred interior pixel.
   typedef struct packed {
      logic [7:0] red_avg;
      logic [7:0] green_avg;
      logic [7:0] blue_avg;
      logic [9:0] out_col;
      logic [9:0] out_row;
      logic       frame_done;
   } result_type;

   // Position tag that travels with a pixel down the pipeline.
   typedef struct packed {
      logic [9:0] out_col;
      logic [9:0] out_row;
      logic       frame_done;
   } meta_type;

   localparam int CSR_AW = 3;
   localparam int CSR_DW = 32;
   localparam int CFG_W  = 11;
   localparam int ROW_W  = 10;

   // Register select is the word address bit paddr[2].
   localparam logic REG_FRAME_WIDTH  = 1'b0;
   localparam logic REG_FRAME_HEIGHT = 1'b1;

   localparam logic [CFG_W-1:0] WIDTH_RESET  = 11'd801;
   localparam logic [CFG_W-1:0] HEIGHT_RESET = 11'd601;
   localparam logic [CFG_W-1:0] DIM_MIN      = 11'd3;
   localparam logic [CFG_W-1:0] HEIGHT_MAX   = 11'd1024;

   // Nine 8-bit samples sum to at most 2295 (12 bits).
   localparam int SUM_W = 12;
   // floor(s/9) == (s*7282) >> 16 for every s <= 2295.
   localparam int RECIP_W     = 13;
   localparam int RECIP_SHIFT = 16;
   localparam logic [RECIP_W-1:0] RECIP_9 = 13'd7282;

   // Output queue; in-flight results plus queued ones never exceed it.
   localparam int FIFO_DEPTH = 8;
   localparam int FIFO_AW    = 3;
   localparam int FIFO_CW    = 4;

endpackage

[sv/bb3_ram.sv]
module bb3_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[sv/box_blur_3x3_rgb_core.sv]
// 3x3 box blur over a raster-order RGB pixel stream.
// req_valid/req_ready/req_data carry one pixel per transfer, left to right and
// top to bottom, in a frame of frame_width x frame_height pixels (APB registers
// at 0x0 and 0x4, saturated to 3..MAX_WIDTH and 3..1024). Any register write
// restarts the frame at column 0, row 0; write only while the block is idle.
// Each interior pixel yields one rsp transfer when the pixel below and right of
// it arrives: the truncated mean of its nine neighbors per channel, its column
// and row, and frame_done on the last interior pixel. Border pixels yield none.
// Results pass the registers of stage 1, the window and sum stages and the
// output FIFO. Throughput: one pixel per clock while req_ready is high,
// limited by the single read and write port of each line memory.
// Results queue in an 8-entry output FIFO; req_ready drops once queued plus
// in-flight results reach 8, so a stalled receiver backs up the input without
// losing anything. Reset restores 801x601, clears the position counters, the
// pipeline and the queue. The two line memories are not cleared: the first two
// rows of each frame fill them before any result reads them.
module box_blur_3x3_rgb_core #(
   parameter int MAX_WIDTH = 1024
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  bb3_pkg::pixel_type           req_data,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output bb3_pkg::result_type          rsp_data,
   input  logic                         psel,
   input  logic                         penable,
   input  logic                         pwrite,
   input  logic [bb3_pkg::CSR_AW-1:0]   paddr,
   input  logic [bb3_pkg::CSR_DW-1:0]   pwdata,
   output logic [bb3_pkg::CSR_DW-1:0]   prdata,
   output logic                         pready
);

   localparam int CW = $clog2(MAX_WIDTH);
   localparam int WW = (CW + 1 > bb3_pkg::CFG_W) ? CW + 1 : bb3_pkg::CFG_W;
   localparam int PROD_W = bb3_pkg::SUM_W + bb3_pkg::RECIP_W;

   // ---------------- configuration ----------------
   logic [bb3_pkg::CFG_W-1:0] frame_width_ff;
   logic [bb3_pkg::CFG_W-1:0] frame_height_ff;
   logic                      cfg_wr;

   assign pready = 1'b1;
   assign cfg_wr = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= bb3_pkg::WIDTH_RESET;
         frame_height_ff <= bb3_pkg::HEIGHT_RESET;
      end else if (cfg_wr) begin
         case (paddr[2])
            bb3_pkg::REG_FRAME_WIDTH:  frame_width_ff  <= pwdata[bb3_pkg::CFG_W-1:0];
            bb3_pkg::REG_FRAME_HEIGHT: frame_height_ff <= pwdata[bb3_pkg::CFG_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (paddr[2])
         bb3_pkg::REG_FRAME_WIDTH:  prdata = bb3_pkg::CSR_DW'(frame_width_ff);
         bb3_pkg::REG_FRAME_HEIGHT: prdata = bb3_pkg::CSR_DW'(frame_height_ff);
         default:                   prdata = '0;
      endcase
   end

   // Saturated frame size, minus one.
   logic [WW-1:0]            width_ext;
   logic [WW-1:0]            width_sat;
   logic [CW-1:0]            last_col;
   logic [bb3_pkg::CFG_W-1:0] height_sat;
   logic [bb3_pkg::ROW_W-1:0] last_row;

   assign width_ext = WW'(frame_width_ff);

   always_comb begin
      if (width_ext < WW'(bb3_pkg::DIM_MIN)) begin
         width_sat = WW'(bb3_pkg::DIM_MIN);
      end else if (width_ext > WW'(MAX_WIDTH)) begin
         width_sat = WW'(MAX_WIDTH);
      end else begin
         width_sat = width_ext;
      end
      if (frame_height_ff < bb3_pkg::DIM_MIN) begin
         height_sat = bb3_pkg::DIM_MIN;
      end else if (frame_height_ff > bb3_pkg::HEIGHT_MAX) begin
         height_sat = bb3_pkg::HEIGHT_MAX;
      end else begin
         height_sat = frame_height_ff;
      end
   end

   assign last_col = CW'(width_sat - WW'(1));
   assign last_row = bb3_pkg::ROW_W'(height_sat - bb3_pkg::CFG_W'(1));

   // ---------------- position counters ----------------
   logic [CW-1:0]             col_ff;
   logic [bb3_pkg::ROW_W-1:0] row_ff;
   logic                      req_xfer;

   assign req_xfer = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (cfg_wr) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (req_xfer) begin
         if (col_ff == last_col) begin
            col_ff <= '0;
            row_ff <= (row_ff == last_row) ? '0 : row_ff + 1'b1;
         end else begin
            col_ff <= col_ff + 1'b1;
         end
      end
   end

   // ---------------- stage 1: pixel accepted, line reads in flight ----------------
   logic                 s1_valid_ff;
   logic                 s1_res_ff;
   logic [CW-1:0]        s1_col_ff;
   bb3_pkg::pixel_type   s1_pix_ff;
   bb3_pkg::meta_type    s1_meta_ff;
   bb3_pkg::meta_type    s1_meta_in;
   logic                 s1_res_in;

   assign s1_res_in           = (col_ff >= CW'(2)) && (row_ff >= bb3_pkg::ROW_W'(2));
   assign s1_meta_in.out_col   = 10'(col_ff - 1'b1);
   assign s1_meta_in.out_row   = row_ff - 1'b1;
   assign s1_meta_in.frame_done = (col_ff == last_col) && (row_ff == last_row);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= req_xfer;
      end
      if (req_xfer) begin
         s1_res_ff  <= s1_res_in;
         s1_col_ff  <= col_ff;
         s1_pix_ff  <= req_data;
         s1_meta_ff <= s1_meta_in;
      end
   end

   // Line two above and line just above; read at the incoming column,
   // rewritten in the following cycle at the same column.
   logic [23:0] top_rd;
   logic [23:0] mid_rd;

   bb3_ram #(.WIDTH(24), .DEPTH(MAX_WIDTH)) u_top_line (
      .clock   (clock),
      .wr_en   (s1_valid_ff),
      .wr_addr (s1_col_ff),
      .wr_data (mid_rd),
      .rd_addr (col_ff),
      .rd_data (top_rd)
   );

   bb3_ram #(.WIDTH(24), .DEPTH(MAX_WIDTH)) u_mid_line (
      .clock   (clock),
      .wr_en   (s1_valid_ff),
      .wr_addr (s1_col_ff),
      .wr_data (s1_pix_ff),
      .rd_addr (col_ff),
      .rd_data (mid_rd)
   );

   // ---------------- stage 2: window shift ----------------
   // win_ff[row][col], column 2 newest.
   bb3_pkg::pixel_type win_ff [3][3];
   logic               s2_valid_ff;
   logic               s2_res_ff;
   bb3_pkg::meta_type  s2_meta_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid_ff;
      end
      if (s1_valid_ff) begin
         for (int r = 0; r < 3; r++) begin
            win_ff[r][0] <= win_ff[r][1];
            win_ff[r][1] <= win_ff[r][2];
         end
         win_ff[0][2] <= top_rd;
         win_ff[1][2] <= mid_rd;
         win_ff[2][2] <= s1_pix_ff;
         s2_res_ff    <= s1_res_ff;
         s2_meta_ff   <= s1_meta_ff;
      end
   end

   // ---------------- stage 3: channel sums ----------------
   logic [bb3_pkg::SUM_W-1:0] red_sum_in;
   logic [bb3_pkg::SUM_W-1:0] green_sum_in;
   logic [bb3_pkg::SUM_W-1:0] blue_sum_in;
   logic [bb3_pkg::SUM_W-1:0] red_sum_ff;
   logic [bb3_pkg::SUM_W-1:0] green_sum_ff;
   logic [bb3_pkg::SUM_W-1:0] blue_sum_ff;
   logic                      s3_valid_ff;
   logic                      s3_res_ff;
   bb3_pkg::meta_type         s3_meta_ff;

   always_comb begin
      red_sum_in   = '0;
      green_sum_in = '0;
      blue_sum_in  = '0;
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            red_sum_in   = red_sum_in   + bb3_pkg::SUM_W'(win_ff[r][c].red_in);
            green_sum_in = green_sum_in + bb3_pkg::SUM_W'(win_ff[r][c].green_in);
            blue_sum_in  = blue_sum_in  + bb3_pkg::SUM_W'(win_ff[r][c].blue_in);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else begin
         s3_valid_ff <= s2_valid_ff;
      end
      if (s2_valid_ff) begin
         red_sum_ff   <= red_sum_in;
         green_sum_ff <= green_sum_in;
         blue_sum_ff  <= blue_sum_in;
         s3_res_ff    <= s2_res_ff;
         s3_meta_ff   <= s2_meta_ff;
      end
   end

   // ---------------- divide by nine via reciprocal ----------------
   logic [PROD_W-1:0]  red_prod;
   logic [PROD_W-1:0]  green_prod;
   logic [PROD_W-1:0]  blue_prod;
   bb3_pkg::result_type result_in;

   assign red_prod   = PROD_W'(red_sum_ff)   * PROD_W'(bb3_pkg::RECIP_9);
   assign green_prod = PROD_W'(green_sum_ff) * PROD_W'(bb3_pkg::RECIP_9);
   assign blue_prod  = PROD_W'(blue_sum_ff)  * PROD_W'(bb3_pkg::RECIP_9);

   assign result_in.red_avg    = red_prod[bb3_pkg::RECIP_SHIFT +: 8];
   assign result_in.green_avg  = green_prod[bb3_pkg::RECIP_SHIFT +: 8];
   assign result_in.blue_avg   = blue_prod[bb3_pkg::RECIP_SHIFT +: 8];
   assign result_in.out_col    = s3_meta_ff.out_col;
   assign result_in.out_row    = s3_meta_ff.out_row;
   assign result_in.frame_done = s3_meta_ff.frame_done;

   // ---------------- output FIFO ----------------
   bb3_pkg::result_type         fifo_ff [bb3_pkg::FIFO_DEPTH];
   logic [bb3_pkg::FIFO_AW-1:0] wr_ptr_ff;
   logic [bb3_pkg::FIFO_AW-1:0] rd_ptr_ff;
   logic [bb3_pkg::FIFO_CW-1:0] fifo_cnt_ff;
   logic [bb3_pkg::FIFO_CW-1:0] pending;
   logic                        fifo_wr;
   logic                        fifo_rd;

   assign fifo_wr   = s3_valid_ff && s3_res_ff;
   assign rsp_valid = (fifo_cnt_ff != '0);
   assign fifo_rd   = rsp_valid && rsp_ready;
   assign rsp_data  = fifo_ff[rd_ptr_ff];

   // Results still to land in the FIFO count against its space.
   assign pending = fifo_cnt_ff
                  + bb3_pkg::FIFO_CW'(s1_valid_ff && s1_res_ff)
                  + bb3_pkg::FIFO_CW'(s2_valid_ff && s2_res_ff)
                  + bb3_pkg::FIFO_CW'(fifo_wr);
   assign req_ready = (pending < bb3_pkg::FIFO_CW'(bb3_pkg::FIFO_DEPTH));

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff   <= '0;
         rd_ptr_ff   <= '0;
         fifo_cnt_ff <= '0;
      end else begin
         if (fifo_wr) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (fifo_rd) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         fifo_cnt_ff <= fifo_cnt_ff + bb3_pkg::FIFO_CW'(fifo_wr)
                        - bb3_pkg::FIFO_CW'(fifo_rd);
      end
      if (fifo_wr) begin
         fifo_ff[wr_ptr_ff] <= result_in;
      end
   end

   // ---------------- assertions ----------------
   a_fifo_no_overflow: assert property (@(posedge clock) disable iff (reset)
      fifo_wr && !fifo_rd |-> fifo_cnt_ff < bb3_pkg::FIFO_CW'(bb3_pkg::FIFO_DEPTH))
      else $error("output FIFO written while full");

   a_pending_bound: assert property (@(posedge clock) disable iff (reset)
      pending <= bb3_pkg::FIFO_CW'(bb3_pkg::FIFO_DEPTH))
      else $error("in-flight results exceed FIFO space");

   a_cfg_restart: assert property (@(posedge clock) disable iff (reset)
      cfg_wr |=> col_ff == '0 && row_ff == '0)
      else $error("register write did not restart the frame");

   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !s1_valid_ff && !s2_valid_ff && !s3_valid_ff && fifo_cnt_ff == '0 |-> req_ready)
      else $error("input stalled with nothing in flight");

endmodule
